>>> design/nco_complex_frequency_shifter_core_defines.svh
// Assertion macros for the NCO complex frequency shifter.
// Used by the top level only; each macro expects clk and rst_n in scope.
`ifndef NCO_COMPLEX_FREQUENCY_SHIFTER_CORE_DEFINES_SVH
`define NCO_COMPLEX_FREQUENCY_SHIFTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define NCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncs assertion failed");

// Next-cycle implication, checked outside reset
`define NCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncs assertion failed");

`endif

>>> design/ncs_pkg.sv
// Shared types, constants and the rounding Q15 multiply of the frequency shifter.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TUNING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;

    // Polynomial coefficients (Q15)
    localparam logic signed [15:0] K_S1  = 16'sd18705;
    localparam logic signed [15:0] K_S3  = -16'sd21166;
    localparam logic signed [15:0] K_S5  = 16'sd2611;
    localparam logic signed [15:0] K_S7  = -16'sd152;
    localparam logic signed [15:0] K_C2  = -16'sd7656;
    localparam logic signed [15:0] K_C4  = 16'sd8311;
    localparam logic signed [15:0] K_C6  = -16'sd683;
    localparam logic signed [15:0] K_C8  = 16'sd30;
    localparam logic signed [15:0] K_ONE = 16'sd32767;

    // One multiply per step on the shared multiplier
    typedef enum logic [4:0] {
        ST_X2   = 5'd0,
        ST_T1   = 5'd1,
        ST_K3   = 5'd2,
        ST_K5   = 5'd3,
        ST_K7   = 5'd4,
        ST_X4   = 5'd5,
        ST_T3   = 5'd6,
        ST_E2   = 5'd7,
        ST_X6   = 5'd8,
        ST_T5   = 5'd9,
        ST_E8A  = 5'd10,
        ST_E4   = 5'd11,
        ST_E6   = 5'd12,
        ST_T7   = 5'd13,
        ST_E8   = 5'd14,
        ST_MI0  = 5'd15,
        ST_MI1  = 5'd16,
        ST_MQ0  = 5'd17,
        ST_MQ1  = 5'd18
    } step_t;

    localparam step_t ST_LAST = ST_MQ1;

    // Controller to datapath commands
    typedef struct packed {
        logic  load_in;
        logic  mul_en;
        step_t step;
        logic  load_out;
    } ncs_cmd_t;

    // ((a*b + 0x4000) >> 15), kept to 16 bits
    function automatic logic signed [15:0] mulr(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic signed [31:0] prod;
        logic [31:0]        rnd;
        prod = a * b;
        rnd  = 32'(prod) + 32'h0000_4000;
        return rnd[30:15];
    endfunction

endpackage

`default_nettype wire

>>> design/ncs_in_if.sv
// Input sample channel: valid/ready handshake with an I/Q payload.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ncs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] in_i;
    logic signed [15:0] in_q;

    modport source (output valid, output in_i, output in_q, input ready);
    modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

`default_nettype wire

>>> design/ncs_out_if.sv
// Result channel: valid/ready handshake with shifted I/Q and the updated phase.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ncs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic signed [31:0] next_phase;

    modport source (output valid, output out_i, output out_q, output next_phase,
                    input ready);
    modport sink   (input valid, input out_i, input out_q, input next_phase,
                    output ready);
endinterface

`default_nettype wire

>>> design/nco_complex_frequency_shifter_core.sv
// NCO complex frequency shifter, top level: sequencer plus datapath.
// Depends on ncs_pkg, ncs_in_if, ncs_out_if, ncs_ctrl, ncs_datapath and the defines header.
//
// Usage:
//   in_ch  (sink)   one complex Q15 sample per item: in_i, in_q.
//   out_ch (source) one result per sample: out_i, out_q (16-bit wrap) and
//                   next_phase, the accumulator after this sample.
//   cfg_we/cfg_index/cfg_data write tuning_word (index 0) or start_phase
//   (index 1); a start_phase write loads the phase accumulator. Other indexes
//   are ignored. Write only while no item is in flight.
// Timing: in_ch.ready is high only between items, so a new item is not taken
//   until the result of the last one is loaded: the 19 products of the sin/cos
//   polynomial and the mixer all go through one 16x16 rounding multiplier, one
//   product per cycle.
// Reset: both registers and the accumulator clear to zero; no item or result
//   is pending.
// Stall: the result sits in the output register until out_ch.ready; the next
//   item may be accepted meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "nco_complex_frequency_shifter_core_defines.svh"

module nco_complex_frequency_shifter_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ncs_in_if.sink                                 in_ch,
    ncs_out_if.source                              out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [ncs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    ncs_pkg::ncs_cmd_t cmd;
    logic              in_ready;
    logic              out_valid;

    // Sequencer
    ncs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Arithmetic
    ncs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_i       (in_ch.in_i),
        .in_q       (in_ch.in_q),
        .out_i      (out_ch.out_i),
        .out_q      (out_ch.out_q),
        .next_phase (out_ch.next_phase)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

    // Checks
    `NCS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ready, !in_ready && cmd.mul_en)
    `NCS_ASSERT_NEXT(a_result_after_load, cmd.load_out, out_valid)
    `NCS_ASSERT_IMP(a_no_accept_while_calc, cmd.mul_en, !in_ready && !cmd.load_out)

endmodule

`default_nettype wire

>>> design/ncs_ctrl.sv
// Sequencer for the shifter: takes an item, steps the shared multiplier, loads the result.
// Depends on ncs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ncs_pkg::ncs_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    ncs_pkg::step_t step_reg, step_next;
    logic           out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd.load_in    = 1'b0;
        cmd.mul_en     = 1'b0;
        cmd.step       = step_reg;
        cmd.load_out   = 1'b0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = ncs_pkg::ST_X2;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == ncs_pkg::ST_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = ncs_pkg::step_t'(step_reg + 5'd1);
                end
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ncs_pkg::ST_X2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/ncs_datapath.sv
// Datapath: phase accumulator, angle fold, shared rounding multiplier with
// sin/cos polynomial and mixer accumulators, output register. Depends on ncs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ncs_pkg::ncs_cmd_t                   cmd,
    input  wire logic                                cfg_we,
    input  wire logic [ncs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                         cfg_data,
    input  wire logic signed [15:0]                  in_i,
    input  wire logic signed [15:0]                  in_q,
    output logic signed [15:0]                       out_i,
    output logic signed [15:0]                       out_q,
    output logic signed [31:0]                       next_phase
);

    logic [31:0]        tuning_reg;
    logic [31:0]        phase_reg;
    logic signed [15:0] si_reg, sq_reg;
    logic signed [15:0] x_reg;
    logic               flip_reg;
    logic signed [15:0] x2_reg, x4_reg, x6_reg;
    logic signed [15:0] k3_reg, k5_reg, k7_reg, e8a_reg;
    logic signed [15:0] sv_reg, cv_reg;
    logic signed [15:0] oi_reg, oq_reg;
    logic signed [15:0] out_i_reg, out_q_reg;
    logic [31:0]        np_reg;

    logic               flip_next;
    logic signed [15:0] ang_raw, x_next;
    logic signed [15:0] cs;
    logic signed [15:0] opa, opb, prod;

    // Fold the top phase bits into the angle; the half-plane flip is
    // phase[31] != phase[30]
    assign flip_next = phase_reg[31] ^ phase_reg[30];
    assign ang_raw   = phase_reg[30:15];
    assign x_next    = flip_next ? 16'(16'sd0 - ang_raw) : ang_raw;

    // Cosine with the half-plane sign applied
    assign cs = flip_reg ? 16'(16'sd0 - cv_reg) : cv_reg;

    // Operand select for the shared multiplier
    always_comb
    begin
        opa = x_reg;
        opb = x_reg;
        unique case (cmd.step)
            ncs_pkg::ST_X2:  begin opa = x_reg;  opb = x_reg;          end
            ncs_pkg::ST_T1:  begin opa = x_reg;  opb = ncs_pkg::K_S1;  end
            ncs_pkg::ST_K3:  begin opa = x_reg;  opb = ncs_pkg::K_S3;  end
            ncs_pkg::ST_K5:  begin opa = x_reg;  opb = ncs_pkg::K_S5;  end
            ncs_pkg::ST_K7:  begin opa = x_reg;  opb = ncs_pkg::K_S7;  end
            ncs_pkg::ST_X4:  begin opa = x2_reg; opb = x2_reg;         end
            ncs_pkg::ST_T3:  begin opa = x2_reg; opb = k3_reg;         end
            ncs_pkg::ST_E2:  begin opa = x2_reg; opb = ncs_pkg::K_C2;  end
            ncs_pkg::ST_X6:  begin opa = x4_reg; opb = x2_reg;         end
            ncs_pkg::ST_T5:  begin opa = x4_reg; opb = k5_reg;         end
            ncs_pkg::ST_E8A: begin opa = x4_reg; opb = ncs_pkg::K_C8;  end
            ncs_pkg::ST_E4:  begin opa = x4_reg; opb = ncs_pkg::K_C4;  end
            ncs_pkg::ST_E6:  begin opa = x6_reg; opb = ncs_pkg::K_C6;  end
            ncs_pkg::ST_T7:  begin opa = x6_reg; opb = k7_reg;         end
            ncs_pkg::ST_E8:  begin opa = x4_reg; opb = e8a_reg;        end
            ncs_pkg::ST_MI0: begin opa = cs;     opb = si_reg;         end
            ncs_pkg::ST_MI1: begin opa = sv_reg; opb = sq_reg;         end
            ncs_pkg::ST_MQ0: begin opa = cs;     opb = sq_reg;         end
            ncs_pkg::ST_MQ1: begin opa = sv_reg; opb = si_reg;         end
            default:         begin opa = x_reg;  opb = x_reg;          end
        endcase
    end

    assign prod = ncs_pkg::mulr(opa, opb);

    // Configuration and phase accumulator (control state)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_reg <= 32'd0;
            phase_reg  <= 32'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == ncs_pkg::REG_TUNING)
            begin
                tuning_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == ncs_pkg::REG_START)
            begin
                phase_reg <= cfg_data;
            end
            else if (cmd.load_in)
            begin
                phase_reg <= phase_reg + tuning_reg;
            end
        end
    end

    // Item capture, product write-back and accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            si_reg   <= in_i;
            sq_reg   <= in_q;
            x_reg    <= x_next;
            flip_reg <= flip_next;
            sv_reg   <= x_next;
            np_reg   <= phase_reg + tuning_reg;
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.step)
                ncs_pkg::ST_X2:
                begin
                    x2_reg <= prod;
                    cv_reg <= 16'(ncs_pkg::K_ONE - prod);
                end
                ncs_pkg::ST_K3:  k3_reg  <= prod;
                ncs_pkg::ST_K5:  k5_reg  <= prod;
                ncs_pkg::ST_K7:  k7_reg  <= prod;
                ncs_pkg::ST_X4:  x4_reg  <= prod;
                ncs_pkg::ST_X6:  x6_reg  <= prod;
                ncs_pkg::ST_E8A: e8a_reg <= prod;
                ncs_pkg::ST_T1, ncs_pkg::ST_T3, ncs_pkg::ST_T5, ncs_pkg::ST_T7:
                    sv_reg <= 16'(sv_reg + prod);
                ncs_pkg::ST_E2, ncs_pkg::ST_E4, ncs_pkg::ST_E6, ncs_pkg::ST_E8:
                    cv_reg <= 16'(cv_reg + prod);
                ncs_pkg::ST_MI0: oi_reg <= prod;
                ncs_pkg::ST_MI1: oi_reg <= 16'(oi_reg - prod);
                ncs_pkg::ST_MQ0: oq_reg <= prod;
                ncs_pkg::ST_MQ1: oq_reg <= 16'(oq_reg + prod);
                default:         oi_reg <= oi_reg;
            endcase
        end
        // output register
        if (cmd.load_out)
        begin
            out_i_reg  <= oi_reg;
            out_q_reg  <= oq_reg;
        end
    end

    // phase result follows the item into the output register
    logic [31:0] np_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            np_out_reg <= np_reg;
        end
    end

    assign out_i      = out_i_reg;
    assign out_q      = out_q_reg;
    assign next_phase = np_out_reg;

endmodule

`default_nettype wire

>>> bench/nco_complex_frequency_shifter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nco_complex_frequency_shifter_core.
// Depends on ncs_pkg, ncs_in_if, ncs_out_if and the core. Every result is predicted
// in-line from the phase accumulator and the sin/cos polynomial.

module nco_complex_frequency_shifter_core_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 30;
    localparam int TIMEOUT_CYC  = 500000;

    // Indexes with no register behind them
    localparam logic [ncs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [ncs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Polynomial coefficients, Q15
    localparam logic signed [15:0] COEF_S1  = 16'sd18705;
    localparam logic signed [15:0] COEF_S3  = -16'sd21166;
    localparam logic signed [15:0] COEF_S5  = 16'sd2611;
    localparam logic signed [15:0] COEF_S7  = -16'sd152;
    localparam logic signed [15:0] COEF_C2  = -16'sd7656;
    localparam logic signed [15:0] COEF_C4  = 16'sd8311;
    localparam logic signed [15:0] COEF_C6  = -16'sd683;
    localparam logic signed [15:0] COEF_C8  = 16'sd30;
    localparam logic signed [15:0] COEF_ONE = 16'sd32767;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic [31:0]        phase;
    } shifted_sample_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ncs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;

    ncs_in_if  in_ch();
    ncs_out_if out_ch();

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;

    // Shadow of the block's registers and accumulator
    logic [31:0] model_tuning;
    logic [31:0] model_accum;

    shifted_sample_t expected_results[$];

    nco_complex_frequency_shifter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Rounding Q15 product, low 16 bits kept
    function automatic logic signed [15:0] q15_mul(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [31:0] prod;
        logic signed [31:0] rounded;
        prod    = a * b;
        rounded = (prod + 32'sd16384) >>> 15;
        return rounded[15:0];
    endfunction

    // Odd/even polynomial for sine and cosine; all sums wrap at 16 bits
    function automatic void angle_to_phasor(input  logic signed [15:0] x,
                                            output logic signed [15:0] s,
                                            output logic signed [15:0] c);
        logic signed [15:0] x2, x4, x6, k3, k5, k7;
        logic signed [15:0] t1, t3, t5, t7, e2, e4, e6, e8a, e8;
        x2  = q15_mul(x, x);
        t1  = q15_mul(x, COEF_S1);
        k3  = q15_mul(x, COEF_S3);
        k5  = q15_mul(x, COEF_S5);
        k7  = q15_mul(x, COEF_S7);
        x4  = q15_mul(x2, x2);
        t3  = q15_mul(x2, k3);
        e2  = q15_mul(x2, COEF_C2);
        x6  = q15_mul(x4, x2);
        t5  = q15_mul(x4, k5);
        e8a = q15_mul(x4, COEF_C8);
        e4  = q15_mul(x4, COEF_C4);
        e6  = q15_mul(x6, COEF_C6);
        t7  = q15_mul(x6, k7);
        e8  = q15_mul(x4, e8a);
        s   = x + t1 + t3 + t5 + t7;
        c   = COEF_ONE - x2 + e2 + e4 + e6 + e8;
    endfunction

    // Mix one sample with the current phasor and advance the accumulator
    function automatic shifted_sample_t predict_shift(input logic signed [15:0] si,
                                                      input logic signed [15:0] sq);
        logic [16:0]        top;
        logic [16:0]        biased;
        logic               fold;
        logic signed [15:0] ang;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        shifted_sample_t    res;
        top    = model_accum[31:15];
        biased = top + 17'h08000;
        fold   = biased[16];
        ang    = top[15:0];
        if (fold)
            ang = -ang;
        angle_to_phasor(ang, sn, cs);
        if (fold)
            cs = -cs;
        res.i       = q15_mul(cs, si) - q15_mul(sn, sq);
        res.q       = q15_mul(cs, sq) + q15_mul(sn, si);
        model_accum = model_accum + model_tuning;
        res.phase   = model_accum;
        return res;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Receiver: random back-pressure, changed at the falling edge
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        shifted_sample_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, i=%0d q=%0d phase=%h",
                         $time, out_ch.out_i, out_ch.out_q, out_ch.next_phase);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_i", want.i, out_ch.out_i);
                check_field("out_q", want.q, out_ch.out_q);
                check_field("next_phase", want.phase, longint'(unsigned'(out_ch.next_phase)));
            end
        end
    end

    // Send one item, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.in_i  = si;
        in_ch.in_q  = sq;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(predict_shift(si, sq));
    endtask

    // Stop sending and wait until every result is out
    task automatic settle_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ncs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        settle_idle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        case (idx)
            ncs_pkg::REG_TUNING: model_tuning = value;
            ncs_pkg::REG_START:  model_accum  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(1, 1 << 20);
            4: return -$urandom_range(1, 1 << 20);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    // Writes to unused indexes must leave tuning and phase alone
    task automatic test_spare_index();
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        send_sample(16'sd12345, -16'sd54);
        send_sample(-16'sd32768, 16'sd32767);
    endtask

    // Field extremes, fold boundaries, the -32768 angle and accumulator wrap
    task automatic test_directed_extremes();
        write_reg(ncs_pkg::REG_TUNING, 32'h0000_0000);
        write_reg(ncs_pkg::REG_START, 32'h0000_0000);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0);
        // angle folds to -32768 at a quarter and three quarters turn
        write_reg(ncs_pkg::REG_START, 32'h4000_0000);
        send_sample(-16'sd32768, -16'sd32768);
        write_reg(ncs_pkg::REG_START, 32'hC000_0000);
        send_sample(16'sd32767, -16'sd32768);
        // accumulator wrap in both directions
        write_reg(ncs_pkg::REG_TUNING, 32'h7FFF_FFFF);
        write_reg(ncs_pkg::REG_START, 32'h8000_0000);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        write_reg(ncs_pkg::REG_TUNING, 32'h8000_0000);
        write_reg(ncs_pkg::REG_START, 32'h7FFF_FFFF);
        send_sample(16'sd1, -16'sd1);
        send_sample(-16'sd32768, -16'sd32768);
        write_reg(ncs_pkg::REG_TUNING, 32'hFFFF_FFFF);
        write_reg(ncs_pkg::REG_START, 32'hFFFF_FFFF);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd1, 16'sd1);
        // step across the fold boundaries one angle unit at a time
        write_reg(ncs_pkg::REG_TUNING, 32'h0000_8000);
        write_reg(ncs_pkg::REG_START, 32'h3FFF_8000);
        send_sample(16'sd32767, 16'sd0);
        send_sample(16'sd32767, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        write_reg(ncs_pkg::REG_START, 32'hBFFF_8000);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, -16'sd32768);
    endtask

    // Bursts of random samples, each under a fresh tuning and often a fresh phase
    task automatic test_random_traffic(input int n_items, input int sender_pct,
                                       input int receiver_pct);
        int sent;
        int burst;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < n_items)
        begin
            write_reg(ncs_pkg::REG_TUNING, pick_word());
            if ($urandom_range(3) != 0)
                write_reg(ncs_pkg::REG_START, pick_word());
            if ($urandom_range(7) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
            burst = $urandom_range(10, 60);
            // last burst only tops up to the requested count
            if (burst > n_items - sent)
                burst = n_items - sent;
            repeat (burst)
            begin
                send_sample(pick_sample(), pick_sample());
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = ncs_pkg::REG_TUNING;
        cfg_data      = 32'h0;
        in_ch.valid   = 1'b0;
        in_ch.in_i    = 16'sd0;
        in_ch.in_q    = 16'sd0;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        model_tuning  = 32'h0;
        model_accum   = 32'h0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_spare_index();
        test_directed_extremes();
        test_random_traffic(410, 33, 62);
        test_random_traffic(410, 62, 33);
        test_random_traffic(410, 0, 0);

        settle_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYC);
        $display("%0t: timeout", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
